// File: sv/bvlp_pkg.sv
package bvlp_pkg;

  localparam int ElemW   = 8;
  localparam int TermW   = 2 * ElemW;
  localparam int SumW    = 27;
  localparam int FracW   = 8;
  localparam int DistW   = 35;
  localparam int RootW   = (SumW + 2 * FracW + 1) / 2;  // 22
  localparam int RadW    = 2 * RootW;                   // 44, padded operand
  localparam int RemW    = RootW + 3;
  localparam int StepCntW = $clog2(RootW);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // norm_order codes
  localparam logic [1:0] NORM_L1 = 2'd1;
  localparam logic [1:0] NORM_L2 = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  operand;
  } sqrt_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

// File: sv/byte_vector_lp_distance.sv
// Byte-vector L1/L2 distance. Each input transaction carries one pair of unsigned
// byte elements; the block sums |p-q| (norm_order = 1) or (p-q)^2 (any other
// code) into a 27-bit accumulator that saturates at full scale. On the pair
// with tlast set it returns one transaction holding the distance in unsigned
// fixed point with 8 fraction bits, rounded down: the sum itself for L1, the
// integer square root of sum*65536 for L2, and clears the accumulator.
// Timing: a pair without tlast is taken and the block is ready again at once.
// A last pair makes the block busy until it returns to idle: for L1 it passes
// through the load state; for L2 it first waits in the root state while the
// square-root unit resolves one result bit per cycle and then raises its done
// flag, and then passes through the load state. The load state writes the
// result into the output register and sets out_tvalid. The next vector's
// pairs are accepted while that result waits to be taken; besides the busy
// states after a last pair, the block holds off in the load state only when a
// new result is ready and the previous one is still untaken.
// norm_order is sampled on every pair; the value present with the last pair
// picks L1 or L2 for the final step. Configuration writes are always accepted.
module byte_vector_lp_distance (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: norm_order
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] p_value, [15:8] q_value
  input  logic        in_tlast,   // last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [34:0] distance, [39:35] zero
);
  import bvlp_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]       norm_r;
  logic             in_xfer;
  logic             out_xfer;
  logic             l1;
  logic [SumW-1:0]  sum_total;
  logic [SumW-1:0]  fin_sum_r, fin_sum_nxt;
  logic             fin_l1_r, fin_l1_nxt;
  logic [DistW-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [RootW-1:0] root;
  sqrt_ctl_t        sq_ctl;
  sqrt_sts_t        sq_sts;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign l1        = (norm_r == NORM_L1);

  bvlp_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (in_xfer),
    .clear     (in_tlast),
    .l1        (l1),
    .p_value   (in_tdata[7:0]),
    .q_value   (in_tdata[15:8]),
    .sum_total (sum_total)
  );

  bvlp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sq_ctl),
    .sts   (sq_sts),
    .root  (root)
  );

  always_comb begin
    state_nxt     = state_r;
    fin_sum_nxt   = fin_sum_r;
    fin_l1_nxt    = fin_l1_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    sq_ctl.start   = 1'b0;
    sq_ctl.operand = sum_total;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_tlast) begin
          fin_sum_nxt = sum_total;
          fin_l1_nxt  = l1;
          if (l1) begin
            state_nxt = ST_LOAD;
          end else begin
            sq_ctl.start = 1'b1;
            state_nxt    = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (sq_sts.done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = fin_l1_r ? {fin_sum_r, {FracW{1'b0}}}
                                   : {{(DistW-RootW){1'b0}}, root};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      norm_r      <= NORM_L2;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        norm_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_sum_r  <= fin_sum_nxt;
    fin_l1_r   <= fin_l1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40-DistW){1'b0}}, out_data_r};

endmodule

// File: sv/bvlp_acc.sv
module bvlp_acc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        clear,
  input  logic                        l1,
  input  logic [bvlp_pkg::ElemW-1:0]  p_value,
  input  logic [bvlp_pkg::ElemW-1:0]  q_value,
  output logic [bvlp_pkg::SumW-1:0]   sum_total
);
  import bvlp_pkg::*;

  logic [SumW-1:0]  running_sum_r, running_sum_nxt;
  logic [ElemW-1:0] diff;
  logic [TermW-1:0] term;
  logic [SumW:0]    wide_sum;

  always_comb begin
    diff = (p_value >= q_value) ? (p_value - q_value) : (q_value - p_value);
    term = l1 ? {{(TermW-ElemW){1'b0}}, diff} : diff * diff;
    wide_sum = {1'b0, running_sum_r} + {{(SumW+1-TermW){1'b0}}, term};
    // saturate at full scale
    sum_total = wide_sum[SumW] ? SumMax : wide_sum[SumW-1:0];
    running_sum_nxt = running_sum_r;
    if (en) begin
      running_sum_nxt = clear ? '0 : sum_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
    end else begin
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule

// File: sv/bvlp_sqrt.sv
module bvlp_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bvlp_pkg::sqrt_ctl_t         ctl,
  output bvlp_pkg::sqrt_sts_t         sts,
  output logic [bvlp_pkg::RootW-1:0]  root
);
  import bvlp_pkg::*;

  logic [RadW-1:0]     rad_r, rad_nxt;
  logic [RemW-1:0]     rem_r, rem_nxt;
  logic [RootW-1:0]    root_r, root_nxt;
  logic [StepCntW-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [RemW-1:0]     rem_sh;
  logic [RemW-1:0]     trial;
  logic                fits;

  // one restoring digit-pair step per cycle
  always_comb begin
    rem_sh = {rem_r[RemW-3:0], rad_r[RadW-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = (rem_sh >= trial);

    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (ctl.start) begin
      rad_nxt  = {{(RadW-SumW-2*FracW){1'b0}}, ctl.operand, {(2*FracW){1'b0}}};
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = StepCntW'(RootW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RadW-3:0], 2'b00};
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[RootW-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule
